>>> sv/assert_macros.svh
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, quiet while rst_ni is low.
`define VDA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vda assertion failed");

// Clocked assertion on clk_i that stays armed through reset.
`define VDA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("vda assertion failed");

`endif

>>> sv/vda_pkg.sv
package vda_pkg;

  // Accumulator and root widths
  localparam int ACC_W  = 48;
  localparam int ROOT_W = ACC_W / 2;

  // Distance modes
  localparam logic [1:0] MODE_L1   = 2'd0;
  localparam logic [1:0] MODE_L2SQ = 2'd1;
  localparam logic [1:0] MODE_L2   = 2'd2;
  localparam logic [1:0] MODE_DOT  = 2'd3;

  // Saturation limits
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Term queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // One classified item: clamped signed term plus control
  typedef struct packed {
    logic [ACC_W-1:0] term;
    logic             ovf;
    logic             last;
    logic [1:0]       mode;
  } term_t;

endpackage

>>> sv/vda_queue.sv
module vda_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vda_pkg::term_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output vda_pkg::term_t rdata_o,
  output logic           empty_o
);

  vda_pkg::term_t                 mem_q [vda_pkg::Q_DEPTH];
  logic [vda_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [vda_pkg::Q_PTR_W:0]      cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (vda_pkg::Q_PTR_W+1)'(vda_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

>>> sv/vda_sqrt.sv
module vda_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vda_pkg::ACC_W-1:0]  value_i,
  output logic                       done_o,
  output logic [vda_pkg::ROOT_W-1:0] root_o
);

  localparam int W = vda_pkg::ACC_W;

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [W-1:0] v_q, v_d;
  logic [W-1:0] root_q, root_d;
  logic [W-1:0] bit_q, bit_d;
  logic [W-1:0] trial;

  assign trial  = root_q + bit_q;
  assign done_o = done_q;
  assign root_o = root_q[vda_pkg::ROOT_W-1:0];

  // restoring square root, each step takes two radicand bits into the remainder; start_i restarts it even while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = value_i;
      root_d = '0;
      bit_d  = {2'b01, {(W-2){1'b0}}};
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d    = v_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

endmodule

>>> sv/vda_front.sv
module vda_front #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic signed [ELEM_WIDTH-1:0] a_value_i,
  input  logic signed [ELEM_WIDTH-1:0] b_value_i,
  input  logic                         last_element_i,
  input  logic [1:0]                   mode_i,
  output logic                         full_o,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output vda_pkg::term_t               q_data_o
);

  localparam int EW = ELEM_WIDTH;
  localparam int PW = 2 * EW;
  localparam int XW = (PW > vda_pkg::ACC_W + 1) ? PW : vda_pkg::ACC_W + 1;
  localparam int AW = vda_pkg::ACC_W;

  // stage 1: operand magnitudes
  logic          s1_v_q;
  logic [EW-1:0] s1_mx_q, s1_my_q;
  logic          s1_neg_q, s1_last_q;
  logic [1:0]    s1_mode_q;
  // stage 2: product
  logic          s2_v_q;
  logic [PW-1:0] s2_prod_q;
  logic          s2_neg_q, s2_last_q;
  logic [1:0]    s2_mode_q;

  logic          s1_free, s2_free;
  logic [EW:0]   a_ext, b_ext, diff, diff_abs, a_abs, b_abs;
  logic [EW-1:0] mx_d, my_d;
  logic          neg_d;
  logic [XW-1:0] prod_ext;
  logic [AW-1:0] term;
  logic          term_ovf;

  // stall chain: a stage moves when the one after it has room
  assign s2_free  = !s2_v_q || !q_full_i;
  assign s1_free  = !s1_v_q || s2_free;
  assign full_o   = !s1_free;
  assign q_push_o = s2_v_q;

  // classify the pair into two multiplier operands
  always_comb begin
    a_ext    = {a_value_i[EW-1], a_value_i};
    b_ext    = {b_value_i[EW-1], b_value_i};
    diff     = a_ext - b_ext;
    diff_abs = diff[EW] ? (~diff + 1'b1) : diff;
    a_abs    = a_ext[EW] ? (~a_ext + 1'b1) : a_ext;
    b_abs    = b_ext[EW] ? (~b_ext + 1'b1) : b_ext;
    neg_d    = 1'b0;
    case (mode_i)
      vda_pkg::MODE_L1: begin
        mx_d = diff_abs[EW-1:0];
        my_d = EW'(1);
      end
      vda_pkg::MODE_DOT: begin
        mx_d  = a_abs[EW-1:0];
        my_d  = b_abs[EW-1:0];
        neg_d = a_value_i[EW-1] ^ b_value_i[EW-1];
      end
      default: begin
        mx_d = diff_abs[EW-1:0];
        my_d = diff_abs[EW-1:0];
      end
    endcase
  end

  // clamp the product into the accumulator range
  always_comb begin
    prod_ext = XW'(s2_prod_q);
    term_ovf = 1'b0;
    if (s2_neg_q) begin
      if (prod_ext > {{(XW-AW){1'b0}}, vda_pkg::ACC_MIN}) begin
        term     = vda_pkg::ACC_MIN;
        term_ovf = 1'b1;
      end else begin
        term = ~prod_ext[AW-1:0] + 1'b1;
      end
    end else begin
      if (prod_ext > {{(XW-AW){1'b0}}, vda_pkg::ACC_MAX}) begin
        term     = vda_pkg::ACC_MAX;
        term_ovf = 1'b1;
      end else begin
        term = prod_ext[AW-1:0];
      end
    end
  end

  assign q_data_o = '{term: term, ovf: term_ovf, last: s2_last_q, mode: s2_mode_q};

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= push_i;
      if (s2_free) s2_v_q <= s1_v_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (s1_free && push_i) begin
      s1_mx_q   <= mx_d;
      s1_my_q   <= my_d;
      s1_neg_q  <= neg_d;
      s1_last_q <= last_element_i;
      s1_mode_q <= mode_i;
    end
    if (s2_free && s1_v_q) begin
      s2_prod_q <= s1_mx_q * s1_my_q;
      s2_neg_q  <= s1_neg_q;
      s2_last_q <= s1_last_q;
      s2_mode_q <= s1_mode_q;
    end
  end

endmodule

>>> sv/vda_back.sv
module vda_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  vda_pkg::term_t            q_data_i,
  output logic                      q_pop_o,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic [vda_pkg::ACC_W-1:0] distance_o,
  output logic                      saturated_o
);

  localparam int AW = vda_pkg::ACC_W;

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] acc_q, acc_d;
  logic          ovf_q, ovf_d;
  logic          pend_sat_q, pend_sat_d;
  logic          res_v_q, res_v_d;
  logic [AW-1:0] res_dist_q, res_dist_d;
  logic          res_sat_q, res_sat_d;

  logic [AW:0]   raw;
  logic [AW-1:0] sum;
  logic          sum_sat;
  logic          out_free;
  logic          take;
  logic          root_start;
  logic [AW-1:0] root_in;
  logic          root_done;
  logic [vda_pkg::ROOT_W-1:0] root;

  vda_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (root_in),
    .done_o  (root_done),
    .root_o  (root)
  );

  // saturating accumulate of the queue head
  always_comb begin
    raw     = {acc_q[AW-1], acc_q} + {q_data_i.term[AW-1], q_data_i.term};
    sum_sat = raw[AW] != raw[AW-1];
    if (sum_sat) sum = raw[AW] ? vda_pkg::ACC_MIN : vda_pkg::ACC_MAX;
    else         sum = raw[AW-1:0];
  end

  assign out_free = !res_v_q || pop_i;
  assign root_in  = sum[AW-1] ? '0 : sum;

  // a last item waits for the result slot unless it heads for the root unit
  assign take = (state_q == ST_ACC) && !q_empty_i &&
                (!q_data_i.last || (q_data_i.mode == vda_pkg::MODE_L2) || out_free);
  assign q_pop_o    = take;
  assign root_start = take && q_data_i.last && (q_data_i.mode == vda_pkg::MODE_L2);

  // sequencer
  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    pend_sat_d = pend_sat_q;
    res_v_d    = res_v_q && !pop_i;
    res_dist_d = res_dist_q;
    res_sat_d  = res_sat_q;
    unique case (state_q)
      ST_ACC: begin
        if (take) begin
          if (q_data_i.last) begin
            acc_d = '0;
            ovf_d = 1'b0;
            if (q_data_i.mode == vda_pkg::MODE_L2) begin
              pend_sat_d = ovf_q | q_data_i.ovf | sum_sat;
              state_d    = ST_ROOT;
            end else begin
              res_v_d    = 1'b1;
              res_dist_d = sum;
              res_sat_d  = ovf_q | q_data_i.ovf | sum_sat;
            end
          end else begin
            acc_d = sum;
            ovf_d = ovf_q | q_data_i.ovf | sum_sat;
          end
        end
      end
      ST_ROOT: begin
        if (root_done) state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          res_v_d    = 1'b1;
          res_dist_d = AW'(root);
          res_sat_d  = pend_sat_q;
          state_d    = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sat_q <= pend_sat_d;
    res_dist_q <= res_dist_d;
    res_sat_q  <= res_sat_d;
  end

  assign empty_o     = !res_v_q;
  assign distance_o  = res_dist_q;
  assign saturated_o = res_sat_q;

endmodule

>>> sv/vector_distance_accumulator.sv
// Streams one pair of vector elements per item and accumulates the L1 distance, squared L2,
// L2 or inner product chosen by distance_mode; the item with last_element set closes the
// vector and yields one result, other items yield none. Items are taken one per cycle while
// full is low: a two-stage front (operand magnitudes, then one ELEM_WIDTH x ELEM_WIDTH
// multiply and clamp) feeds a four-entry term queue, and the back adds one term per cycle,
// unless it is waiting on the root unit or the result slot, into a saturating 48-bit
// accumulator. In L2 mode the square root of the sum is found one result bit per cycle,
// so closing a vector holds the back until the root is done; the queue absorbs the first
// items of the next vector, after which full rises until the root is delivered. The result
// slot holds one finished result; a closing item waits while it stays unpopped.
module vector_distance_accumulator #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             distance_mode_we_i,
  input  logic [1:0]                       distance_mode_i,
  input  logic                             push,
  output logic                             full,
  input  logic signed [ELEM_WIDTH-1:0]     a_value_i,
  input  logic signed [ELEM_WIDTH-1:0]     b_value_i,
  input  logic                             last_element_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [vda_pkg::ACC_W-1:0] distance_o,
  output logic                             saturated_o
);

  logic [1:0]     mode_q;
  logic           q_full, q_empty, q_push, q_pop;
  vda_pkg::term_t q_wdata, q_rdata;
  logic [vda_pkg::ACC_W-1:0] back_distance;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vda_pkg::MODE_L1;
    end else if (distance_mode_we_i) begin
      mode_q <= distance_mode_i;
    end
  end

  vda_front #(.ELEM_WIDTH(ELEM_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .a_value_i      (a_value_i),
    .b_value_i      (b_value_i),
    .last_element_i (last_element_i),
    .mode_i         (mode_q),
    .full_o         (full),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  vda_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  vda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .distance_o  (back_distance),
    .saturated_o (saturated_o)
  );

  assign distance_o = back_distance;

endmodule

>>> sv/vda_checker.sv
`include "assert_macros.svh"

module vda_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             distance_mode_we_i,
  input logic [1:0]                       distance_mode_i,
  input logic                             push,
  input logic                             full,
  input logic                             last_element_i,
  input logic                             empty,
  input logic                             pop,
  input logic signed [vda_pkg::ACC_W-1:0] distance_o,
  input logic                             saturated_o
);

  localparam int AW = vda_pkg::ACC_W;
  localparam int RW = vda_pkg::ROOT_W;

  logic [1:0] mode_q;
  logic [3:0] pending_q;
  logic       in_last, out_take;

  assign in_last  = push && !full && last_element_i;
  assign out_take = pop && !empty;

  // shadow of the mode register and count of closed vectors not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= vda_pkg::MODE_L1;
      pending_q <= '0;
    end else begin
      if (distance_mode_we_i) mode_q <= distance_mode_i;
      if (in_last && !out_take)      pending_q <= pending_q + 1'b1;
      else if (out_take && !in_last) pending_q <= pending_q - 1'b1;
    end
  end

  // a waiting result holds still
  `VDA_ASSERT(a_hold, !empty && !pop |=> $stable(distance_o) && $stable(saturated_o))
  // no result without a closed vector
  `VDA_ASSERT(a_no_spurious, !empty |-> pending_q != '0)
  // leaving reset, nothing is held and input is open
  `VDA_ASSERT(a_reset_idle, $rose(rst_ni) |-> empty && !full)
  // a root fits in half the accumulator width
  `VDA_ASSERT(a_root_width, !empty && mode_q == vda_pkg::MODE_L2 |-> distance_o[AW-1:RW] == '0)

endmodule

bind vector_distance_accumulator vda_checker u_vda_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .distance_mode_we_i (distance_mode_we_i),
  .distance_mode_i    (distance_mode_i),
  .push               (push),
  .full               (full),
  .last_element_i     (last_element_i),
  .empty              (empty),
  .pop                (pop),
  .distance_o         (distance_o),
  .saturated_o        (saturated_o)
);

>>> dv/vector_distance_accumulator_test.sv
`timescale 1ns / 1ps

module vector_distance_accumulator_test;

  localparam int EW = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 118;
  localparam int PLAN_ROWS = 23;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic [vda_pkg::ACC_W-1:0] distance;
    logic                      sat;
  } dist_item_t;

  typedef struct {
    bit                        set_mode;
    logic [1:0]                mode;
    logic signed [EW-1:0]      a;
    logic signed [EW-1:0]      b;
    bit                        last;
    int                        rep;
    bit                        typed;
    logic [vda_pkg::ACC_W-1:0] exp_dist;
    bit                        exp_sat;
  } plan_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic mode_we = 1'b0;
  logic [1:0] mode_data = vda_pkg::MODE_L1;
  logic push = 1'b0;
  logic full;
  logic signed [EW-1:0] a_val = '0;
  logic signed [EW-1:0] b_val = '0;
  logic last_el = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [vda_pkg::ACC_W-1:0] dist_out;
  logic sat_out;

  // Predictor state: mode register, running sum and sticky overflow
  logic [1:0] mode_q = vda_pkg::MODE_L1;
  longint sum_q = 0;
  bit sat_q = 1'b0;

  dist_item_t distance_q[$];
  int errors = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  plan_row_t plan [PLAN_ROWS];
  logic [1:0] phase_modes [4] = '{vda_pkg::MODE_L1, vda_pkg::MODE_L2SQ, vda_pkg::MODE_L2,
                                  vda_pkg::MODE_DOT};

  vector_distance_accumulator #(.ELEM_WIDTH(EW)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .distance_mode_we_i (mode_we),
    .distance_mode_i    (mode_data),
    .push               (push),
    .full               (full),
    .a_value_i          (a_val),
    .b_value_i          (b_val),
    .last_element_i     (last_el),
    .empty              (empty),
    .pop                (pop),
    .distance_o         (dist_out),
    .saturated_o        (sat_out)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Accumulate one element pair; returns 1 with the result when the vector closes
  function automatic bit accumulate_pair(input logic signed [EW-1:0] a, b, input bit last,
                                         output dist_item_t res);
    longint av, bv, term, total, root, trial;
    res = '0;
    av = longint'(a);
    bv = longint'(b);
    case (mode_q)
      vda_pkg::MODE_DOT: term = av * bv;
      vda_pkg::MODE_L1:  term = (av > bv) ? av - bv : bv - av;
      default:           term = (av - bv) * (av - bv);
    endcase
    total = sum_q + term;
    if (total > SUM_MAX) begin
      total = SUM_MAX;
      sat_q = 1'b1;
    end else if (total < SUM_MIN) begin
      total = SUM_MIN;
      sat_q = 1'b1;
    end
    sum_q = total;
    if (!last) return 1'b0;
    // floor root, bit by bit from the top; a negative sum gives zero
    if (mode_q == vda_pkg::MODE_L2) begin
      root = 0;
      if (total > 0) begin
        for (int i = 23; i >= 0; i--) begin
          trial = root | (64'sd1 << i);
          if (trial * trial <= total) root = trial;
        end
      end
      total = root;
    end
    res.distance = total[vda_pkg::ACC_W-1:0];
    res.sat = sat_q;
    sum_q = 0;
    sat_q = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [EW-1:0] pick_elem();
    case ($urandom_range(5))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3:    return EW'(int'($urandom_range(400)) - 200);
      default: return EW'($urandom);
    endcase
  endfunction

  function automatic void flag_error(string what, dist_item_t want, dist_item_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected distance %0d sat %0b, got distance %0d sat %0b",
               $realtime, what, $signed(want.distance), want.sat, $signed(got.distance),
               got.sat);
  endfunction

  // Offer one item, with random gaps while idle_on is set, and record the expected result when it closes a vector
  task automatic send_item(input logic signed [EW-1:0] a, b, input bit last,
                           input bit typed = 1'b0, input dist_item_t typed_res = '0);
    dist_item_t res;
    while (idle_on && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    a_val <= a;
    b_val <= b;
    last_el <= last;
    do @(posedge clk_i); while (full);
    if (accumulate_pair(a, b, last, res))
      distance_q.insert(distance_q.size(), typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  // Mode write only once the block has gone quiet
  task automatic write_mode(input logic [1:0] m);
    push <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    mode_we <= 1'b1;
    mode_data <= m;
    @(negedge clk_i);
    mode_we <= 1'b0;
    mode_q = m;
  endtask

  // Result side: random pops, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      pop <= !idle_on || ($urandom_range(99) >= 22);
    end
  end

  // Compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    dist_item_t want, got;
    if (rst_ni && pop && !empty) begin
      got.distance = dist_out;
      got.sat = sat_out;
      if (distance_q.size() == 0) begin
        flag_error("result with none expected", '0, got);
      end else begin
        want = distance_q.pop_front();
        if (got.distance !== want.distance) flag_error("distance mismatch", want, got);
        if (got.sat !== want.sat) flag_error("saturated mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("vector_distance_accumulator_test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int sent, len;
    logic [1:0] m;
    dist_item_t typed_res;
    // set_mode, mode, a, b, last, rep, typed, exp_dist, exp_sat
    plan = '{
      '{0, vda_pkg::MODE_L1,   16'sh0000, 16'sh0000, 1, 1, 1, 48'd0, 0},  // reset mode
      '{1, vda_pkg::MODE_L1,   16'sh7FFF, 16'sh8000, 1, 1, 1, 48'd65535, 0},
      '{0, vda_pkg::MODE_L1,   16'sh8000, 16'sh7FFF, 0, 1, 0, '0, 0},
      '{0, vda_pkg::MODE_L1,   16'sh0001, 16'sh0001, 1, 1, 0, '0, 0},
      '{1, vda_pkg::MODE_L2SQ, 16'sh8000, 16'sh7FFF, 1, 1, 1, 48'd4294836225, 0},
      '{0, vda_pkg::MODE_L2SQ, 16'sh8000, 16'sh7FFF, 1, 8, 0, '0, 0},
      '{0, vda_pkg::MODE_L2SQ, 16'sh0005, 16'sh0002, 1, 1, 1, 48'd9, 0},
      '{1, vda_pkg::MODE_L2,   16'sh8000, 16'sh7FFF, 1, 1, 1, 48'd65535, 0},
      '{0, vda_pkg::MODE_L2,   16'sh0003, 16'sh0000, 0, 1, 0, '0, 0},
      '{0, vda_pkg::MODE_L2,   16'sh0000, 16'sh0004, 1, 1, 1, 48'd5, 0},
      '{0, vda_pkg::MODE_L2,   16'sh0001, 16'sh0000, 0, 1, 0, '0, 0},
      '{0, vda_pkg::MODE_L2,   16'sh0001, 16'sh0000, 1, 1, 0, '0, 0},  // root rounds down
      '{0, vda_pkg::MODE_L2,   16'sh8000, 16'sh7FFF, 1, 8, 0, '0, 0},  // root of a longer sum
      '{1, vda_pkg::MODE_DOT,  16'sh8000, 16'sh8000, 1, 1, 1, 48'd1073741824, 0},
      '{0, vda_pkg::MODE_DOT,  16'sh8000, 16'sh7FFF, 1, 1, 1, 48'hFFFF_C000_8000, 0},
      '{0, vda_pkg::MODE_DOT,  16'sh7FFF, 16'sh7FFF, 1, 1, 0, '0, 0},
      '{0, vda_pkg::MODE_DOT,  16'sh8000, 16'sh7FFF, 1, 8, 0, '0, 0},
      '{0, vda_pkg::MODE_DOT,  16'shFF9C, 16'sh0064, 0, 1, 0, '0, 0},  // sum left negative
      '{1, vda_pkg::MODE_L2,   16'sh0000, 16'sh0000, 1, 1, 1, 48'd0, 0},  // negative under root
      '{1, vda_pkg::MODE_L1,   16'sh0007, 16'shFFF9, 0, 1, 0, '0, 0},
      '{1, vda_pkg::MODE_DOT,  16'sh0002, 16'sh0003, 1, 1, 0, '0, 0},  // mode change mid-vector
      '{1, vda_pkg::MODE_L2SQ, 16'sh0000, 16'shFFFF, 1, 1, 0, '0, 0},
      '{1, vda_pkg::MODE_L1,   16'sh1234, 16'shEDCB, 1, 1, 0, '0, 0}
    };

    // Reset
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; long runs go without gaps
    foreach (plan[r]) begin
      if (plan[r].set_mode) write_mode(plan[r].mode);
      idle_on = (plan[r].rep == 1);
      typed_res.distance = plan[r].exp_dist;
      typed_res.sat = plan[r].exp_sat;
      for (int k = 0; k < plan[r].rep; k++)
        send_item(plan[r].a, plan[r].b, plan[r].last && (k == plan[r].rep - 1),
                  plan[r].typed, typed_res);
    end

    // Random vectors, one mode per phase
    for (int p = 0; p < 8; p++) begin
      m = (p < 4) ? phase_modes[p] : 2'($urandom_range(3));
      write_mode(m);
      idle_on = (p != 5);
      // short vectors under a long receiver hold-off fill the block
      if (p == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 3) len = $urandom_range(1, 2);
        else if ($urandom_range(4) == 0) len = $urandom_range(7, 30);
        else len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) send_item(pick_elem(), pick_elem(), k == len - 1);
        sent += len;
      end
      // leave a vector open across the next mode change
      if (p < 7 && $urandom_range(1) == 1) begin
        len = $urandom_range(1, 3);
        repeat (len) send_item(pick_elem(), pick_elem(), 1'b0);
      end
    end

    // Drain
    push <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("vector_distance_accumulator_test passed");
    end else begin
      $display("vector_distance_accumulator_test failed");
    end
    $finish;
  end

endmodule
